// ===== src/cvm_pkg.sv =====
// ----------------------------------------------------------------------------
// cvm_pkg
// shared types, constants and helper functions of the character video,
// memory and keyboard unit
// ----------------------------------------------------------------------------
package cvm_pkg;

    localparam int EXPANSION_BYTES = 32768;
    localparam int EXP_AW          = $clog2(EXPANSION_BYTES);
    localparam int CLR_AW          = 10;

    localparam logic [15:0] ROM_END   = 16'h2000;
    localparam logic [15:0] VIDEO_END = 16'h2800;
    localparam logic [15:0] GLYPH_END = 16'h3000;
    localparam logic [15:0] WORK_END  = 16'h4000;
    localparam logic [7:0]  KEY_FILL  = 8'hC0;
    localparam logic [7:0]  ODD_PORT  = 8'hFF;

    typedef enum logic [2:0] {
        OP_MEM_RD = 3'd0,
        OP_MEM_WR = 3'd1,
        OP_IO_RD  = 3'd2,
        OP_IO_WR  = 3'd3,
        OP_PIXEL  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        RG_ROM,
        RG_VIDEO,
        RG_GLYPH,
        RG_WORK,
        RG_EXP
    } region_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_GLYPH
    } state_t;

    typedef struct packed {
        logic take;
        logic glyph_rd;
        logic load_out;
        logic clear_wr;
    } cvm_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic pixel_op;
    } cvm_stat_t;

    function automatic region_t region_of(input logic [15:0] addr);
        region_t r;
        if (addr < ROM_END)
            r = RG_ROM;
        else if (addr < VIDEO_END)
            r = RG_VIDEO;
        else if (addr < GLYPH_END)
            r = RG_GLYPH;
        else if (addr < WORK_END)
            r = RG_WORK;
        else
            r = RG_EXP;
        return r;
    endfunction

    // offset from 0x4000 folded onto the expansion size by restoring steps
    function automatic logic [EXP_AW-1:0] exp_index(input logic [15:0] addr);
        logic [19:0] rem;
        logic [19:0] step;
        rem = {5'd0, ~addr[14], addr[13:0]};
        for (int k = 4; k >= 0; k--)
        begin
            step = 20'(EXPANSION_BYTES) << k;
            if (rem >= step)
                rem = rem - step;
        end
        return rem[EXP_AW-1:0];
    endfunction

    function automatic logic [7:0] key_byte(input logic [15:0] addr,
                                            input logic [39:0] keys,
                                            input logic        ear);
        logic [4:0] pressed;
        pressed = '0;
        for (int row = 0; row < 8; row++)
        begin
            if (!addr[8 + row])
                pressed = pressed | keys[5*row +: 5];
        end
        return KEY_FILL | {2'b00, ear, ~pressed};
    endfunction

endpackage

// ===== src/cvm_req_if.sv =====
// ----------------------------------------------------------------------------
// cvm_req_if
// request channel: memory, io and pixel items
// ----------------------------------------------------------------------------
interface cvm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [39:0] key_matrix;
    logic        tape_ear;

    modport source (output valid, op, address, write_data, pixel_x, pixel_y,
                    key_matrix, tape_ear, input ready);
    modport sink (input valid, op, address, write_data, pixel_x, pixel_y,
                  key_matrix, tape_ear, output ready);
endinterface

// ===== src/cvm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cvm_rsp_if
// response channel: one result item per request item
// ----------------------------------------------------------------------------
interface cvm_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       rom_hit;
    logic       pixel_on;
    logic       beeper_level;

    modport source (output valid, read_data, rom_hit, pixel_on, beeper_level,
                    input ready);
    modport sink (input valid, read_data, rom_hit, pixel_on, beeper_level,
                  output ready);
endinterface

// ===== src/cvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// cvm_ctrl
// sequencer: store clearing after reset, item intake, two-step pixel
// lookup and output register handshake
// ----------------------------------------------------------------------------
module cvm_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  cvm_pkg::cvm_stat_t stat,
    output cvm_pkg::cvm_cmd_t  cmd
);
    import cvm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_READ;
            end
            S_READ:
            begin
                if (stat.pixel_op)
                    state_next = S_GLYPH;
                else if (slot_free)
                    state_next = S_IDLE;
            end
            S_GLYPH:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd.take     = (state_reg == S_IDLE) && req_valid;
        cmd.glyph_rd = (state_reg == S_READ) && stat.pixel_op;
        cmd.load_out = ((state_reg == S_READ) && !stat.pixel_op && slot_free)
                    || ((state_reg == S_GLYPH) && slot_free);
        cmd.clear_wr = (state_reg == S_CLEAR);
        req_ready    = (state_reg == S_IDLE);
        rsp_valid    = out_valid_reg;
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_take_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> (state_reg == S_READ) && !req_ready)
        else $error("item taken but sequencer did not start the read");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || rsp_ready))
        else $error("output register overwritten while its item waits");

    a_glyph_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GLYPH) |->
            ($past(state_reg) == S_READ || $past(state_reg) == S_GLYPH))
        else $error("glyph step entered without a video read");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            ($past(state_reg) == S_READ || $past(state_reg) == S_GLYPH))
        else $error("result raised outside a read step");

endmodule

// ===== src/cvm_dp.sv =====
// ----------------------------------------------------------------------------
// cvm_dp
// datapath: video, glyph, work and expansion stores, beeper flag,
// keyboard port, pixel lookup and output register
// ----------------------------------------------------------------------------
module cvm_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  cvm_pkg::cvm_cmd_t  cmd,
    output cvm_pkg::cvm_stat_t stat,
    input  logic [2:0]         op,
    input  logic [15:0]        address,
    input  logic [7:0]         write_data,
    input  logic [7:0]         pixel_x,
    input  logic [7:0]         pixel_y,
    input  logic [39:0]        key_matrix,
    input  logic               tape_ear,
    output logic [7:0]         read_data,
    output logic               rom_hit,
    output logic               pixel_on,
    output logic               beeper_level
);
    import cvm_pkg::*;

    logic [7:0] video_mem [1024];
    logic [7:0] glyph_mem [1024];
    logic [7:0] work_mem  [1024];
    logic [7:0] exp_mem   [EXPANSION_BYTES];

    logic [7:0] video_q;
    logic [7:0] glyph_q;
    logic [7:0] work_q;
    logic [7:0] exp_q;

    logic [CLR_AW-1:0] clr_cnt_reg;
    logic [2:0]        op_reg;
    region_t           region_reg;
    logic [7:0]        io_byte_reg;
    logic [2:0]        px_bit_reg;
    logic [2:0]        py_row_reg;
    logic              beeper_reg;
    logic              beeper_next;

    logic [7:0] read_data_reg;
    logic       rom_hit_reg;
    logic       pixel_on_reg;
    logic       beeper_level_reg;

    region_t           region;
    logic              mem_wr;
    logic              video_we;
    logic              glyph_we;
    logic [9:0]        clr_addr;
    logic [9:0]        video_wa;
    logic [9:0]        glyph_wa;
    logic [7:0]        fill_data;
    logic [9:0]        video_ra;
    logic [9:0]        glyph_ra;
    logic [EXP_AW-1:0] exp_addr;
    logic [7:0]        rd_sel;
    logic              glyph_bit;

    assign region    = region_of(address);
    assign mem_wr    = cmd.take && (op == OP_MEM_WR);
    assign video_we  = cmd.clear_wr || (mem_wr && region == RG_VIDEO);
    assign glyph_we  = cmd.clear_wr || (mem_wr && region == RG_GLYPH);
    assign clr_addr  = clr_cnt_reg;
    assign video_wa  = cmd.clear_wr ? clr_addr : address[9:0];
    assign glyph_wa  = cmd.clear_wr ? clr_addr : address[9:0];
    assign fill_data = cmd.clear_wr ? 8'h00 : write_data;
    assign video_ra  = (op == OP_PIXEL) ? {pixel_y[7:3], pixel_x[7:3]} : address[9:0];
    assign glyph_ra  = cmd.glyph_rd ? {video_q[6:0], py_row_reg} : address[9:0];
    assign exp_addr  = exp_index(address);

    always_ff @(posedge clk)
    begin
        if (video_we)
            video_mem[video_wa] <= fill_data;
        if (cmd.take)
            video_q <= video_mem[video_ra];
    end

    always_ff @(posedge clk)
    begin
        if (glyph_we)
            glyph_mem[glyph_wa] <= fill_data;
        if (cmd.take || cmd.glyph_rd)
            glyph_q <= glyph_mem[glyph_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr && region == RG_WORK)
            work_mem[address[9:0]] <= write_data;
        if (cmd.take)
            work_q <= work_mem[address[9:0]];
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr && region == RG_EXP)
            exp_mem[exp_addr] <= write_data;
        if (cmd.take)
            exp_q <= exp_mem[exp_addr];
    end

    always_comb
    begin
        beeper_next = beeper_reg;
        if (cmd.take && !address[0])
        begin
            if (op == OP_IO_RD)
                beeper_next = 1'b0;
            else if (op == OP_IO_WR)
                beeper_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            beeper_reg  <= 1'b0;
        end
        else
        begin
            beeper_reg <= beeper_next;
            if (cmd.clear_wr)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg      <= op;
            region_reg  <= region;
            io_byte_reg <= address[0] ? ODD_PORT : key_byte(address, key_matrix, tape_ear);
            px_bit_reg  <= pixel_x[2:0];
            py_row_reg  <= pixel_y[2:0];
        end
    end

    always_comb
    begin
        case (region_reg)
            RG_VIDEO: rd_sel = video_q;
            RG_GLYPH: rd_sel = glyph_q;
            RG_WORK:  rd_sel = work_q;
            RG_EXP:   rd_sel = exp_q;
            default:  rd_sel = 8'h00;
        endcase
    end

    assign glyph_bit = glyph_q[~px_bit_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (op_reg == OP_MEM_RD)
                read_data_reg <= rd_sel;
            else if (op_reg == OP_IO_RD)
                read_data_reg <= io_byte_reg;
            else
                read_data_reg <= 8'h00;
            rom_hit_reg      <= (op_reg == OP_MEM_RD) && (region_reg == RG_ROM);
            pixel_on_reg     <= (op_reg == OP_PIXEL) && (glyph_bit ^ video_q[7]);
            beeper_level_reg <= beeper_reg;
        end
    end

    assign stat.clear_last = cmd.clear_wr && (clr_cnt_reg == {CLR_AW{1'b1}});
    assign stat.pixel_op   = (op_reg == OP_PIXEL);

    assign read_data    = read_data_reg;
    assign rom_hit      = rom_hit_reg;
    assign pixel_on     = pixel_on_reg;
    assign beeper_level = beeper_level_reg;

    a_glyph_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.glyph_rd |-> $past(cmd.take))
        else $error("glyph read without a fresh video code");

    a_no_clear_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> !cmd.take && !cmd.load_out)
        else $error("item handled during store clearing");

    a_beeper_io_only: assert property (@(posedge clk) disable iff (!rst_n)
        (beeper_reg != $past(beeper_reg)) |->
            ($past(cmd.take) && ($past(op) == OP_IO_RD || $past(op) == OP_IO_WR)))
        else $error("beeper changed outside an io access");

endmodule

// ===== src/char_video_memory_and_keyboard_io_unit.sv =====
// ----------------------------------------------------------------------------
// char_video_memory_and_keyboard_io_unit
// character video stores, work and expansion ram, beeper flag and keyboard
// matrix port behind one request channel and one response channel
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid / ready  op, address, write_data, pixel_x, pixel_y,
//                               key_matrix, tape_ear
//  rsp      out  valid / ready  read_data, rom_hit, pixel_on, beeper_level
//
//  one item at a time: memory and io items pass a read step; pixel items add
//  a glyph step, since the glyph read depends on the registered video read
//  after reset a pass over all 1024 addresses zeroes the video and glyph
//  stores; req.ready stays low during it
//  a stalled rsp holds the finished item in the output register; the next
//  item is taken and read while it waits
// ----------------------------------------------------------------------------
module char_video_memory_and_keyboard_io_unit
(
    input logic    clk,
    input logic    rst_n,
    cvm_req_if.sink   req,
    cvm_rsp_if.source rsp
);
    import cvm_pkg::*;

    cvm_cmd_t  cmd;
    cvm_stat_t stat;

    cvm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cvm_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (req.op),
        .address      (req.address),
        .write_data   (req.write_data),
        .pixel_x      (req.pixel_x),
        .pixel_y      (req.pixel_y),
        .key_matrix   (req.key_matrix),
        .tape_ear     (req.tape_ear),
        .read_data    (rsp.read_data),
        .rom_hit      (rsp.rom_hit),
        .pixel_on     (rsp.pixel_on),
        .beeper_level (rsp.beeper_level)
    );

endmodule

// ===== verif/char_video_memory_and_keyboard_io_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_video_memory_and_keyboard_io_unit_test
// self-checking bench for the character video, memory and keyboard unit.
// memory, io and pixel items go in through bursts with random gaps while the
// response side stalls on its own pattern. a local copy of the stores, the
// beeper and the keyboard port predicts every response, which is compared
// field by field in arrival order.
// ----------------------------------------------------------------------------
module char_video_memory_and_keyboard_io_unit_test;
    import cvm_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PRINT_LIMIT  = 200;

    typedef struct {
        op_t         op;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [39:0] key_matrix;
        logic        tape_ear;
    } access_t;

    typedef struct {
        logic [7:0] read_data;
        logic       rom_hit;
        logic       pixel_on;
        logic       beeper_level;
    } response_t;

    logic clk;
    logic rst_n;

    cvm_req_if req ();
    cvm_rsp_if rsp ();

    char_video_memory_and_keyboard_io_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // local copy of the block state
    logic [7:0] video_copy [1024];
    logic [7:0] glyph_copy [1024];
    logic [7:0] work_copy  [1024];
    logic [7:0] exp_copy   [EXPANSION_BYTES];
    bit         work_known [1024];
    bit         exp_known  [EXPANSION_BYTES];
    int         work_slots [$];
    int         exp_slots  [$];
    logic       beeper_copy;

    response_t  pending_responses [$];
    response_t  want_rsp;

    int  error_count;
    int  responses_checked;
    int  cycle_count;
    int  op_items [5];
    int  burst_left;
    bit  gaps_on;
    int  hold_requests;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_responses.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (error_count < PRINT_LIMIT)
            $display("mismatch %s at response %0d: got %h expected %h",
                     what, responses_checked, got, want);
        error_count++;
    endtask

    function automatic access_t build_access(input op_t op, input logic [15:0] address,
                                             input logic [7:0] write_data,
                                             input logic [7:0] pixel_x,
                                             input logic [7:0] pixel_y,
                                             input logic [39:0] key_matrix,
                                             input logic tape_ear);
        access_t a;
        a.op         = op;
        a.address    = address;
        a.write_data = write_data;
        a.pixel_x    = pixel_x;
        a.pixel_y    = pixel_y;
        a.key_matrix = key_matrix;
        a.tape_ear   = tape_ear;
        return a;
    endfunction

    function automatic int exp_slot(input logic [15:0] address);
        logic [15:0] offset;
        offset = address - WORK_END;
        return int'(offset[14:0]) % EXPANSION_BYTES;
    endfunction

    function automatic logic [7:0] keyboard_read(input logic [15:0] port,
                                                 input logic [39:0] keys,
                                                 input logic ear);
        logic [4:0] down;
        down = '0;
        for (int r = 0; r < 8; r++)
        begin
            if (port[8 + r] == 1'b0)
                down = down | keys[5*r +: 5];
        end
        return {2'b11, ear, ~down};
    endfunction

    // applies one item to the local copy and returns the response it causes
    function automatic response_t access_result(input access_t a);
        response_t  r;
        int         idx;
        logic [9:0] tile;
        logic [7:0] code;
        logic [7:0] glyph_row;
        r.read_data = 8'h00;
        r.rom_hit   = 1'b0;
        r.pixel_on  = 1'b0;
        case (a.op)
            OP_MEM_RD:
            begin
                if (a.address < ROM_END)
                    r.rom_hit = 1'b1;
                else if (a.address < VIDEO_END)
                    r.read_data = video_copy[a.address[9:0]];
                else if (a.address < GLYPH_END)
                    r.read_data = glyph_copy[a.address[9:0]];
                else if (a.address < WORK_END)
                    r.read_data = work_copy[a.address[9:0]];
                else
                    r.read_data = exp_copy[exp_slot(a.address)];
            end
            OP_MEM_WR:
            begin
                if (a.address < ROM_END)
                begin
                    // rom write dropped
                end
                else if (a.address < VIDEO_END)
                    video_copy[a.address[9:0]] = a.write_data;
                else if (a.address < GLYPH_END)
                    glyph_copy[a.address[9:0]] = a.write_data;
                else if (a.address < WORK_END)
                begin
                    idx = int'(a.address[9:0]);
                    work_copy[idx] = a.write_data;
                    if (!work_known[idx])
                    begin
                        work_known[idx] = 1'b1;
                        work_slots.push_back(idx);
                    end
                end
                else
                begin
                    idx = exp_slot(a.address);
                    exp_copy[idx] = a.write_data;
                    if (!exp_known[idx])
                    begin
                        exp_known[idx] = 1'b1;
                        exp_slots.push_back(idx);
                    end
                end
            end
            OP_IO_RD:
            begin
                if (a.address[0] == 1'b0)
                begin
                    beeper_copy = 1'b0;
                    r.read_data = keyboard_read(a.address, a.key_matrix, a.tape_ear);
                end
                else
                    r.read_data = 8'hFF;
            end
            OP_IO_WR:
            begin
                if (a.address[0] == 1'b0)
                    beeper_copy = 1'b1;
            end
            OP_PIXEL:
            begin
                tile      = {a.pixel_y[7:3], a.pixel_x[7:3]};
                code      = video_copy[tile];
                glyph_row = glyph_copy[{code[6:0], a.pixel_y[2:0]}];
                r.pixel_on = glyph_row[~a.pixel_x[2:0]] ^ code[7];
            end
            default:
            begin
            end
        endcase
        r.beeper_level = beeper_copy;
        return r;
    endfunction

    function automatic access_t random_access();
        access_t     a;
        logic [39:0] keys;
        int          pick;
        int          region;
        int          slot;
        case ($urandom_range(0, 3))
            0: keys = {8'($urandom), 32'($urandom)};
            1: keys = 40'd1 << $urandom_range(0, 39);
            2: keys = '0;
            default: keys = {8'($urandom), 32'($urandom)} & {8'($urandom), 32'($urandom)}
                            & {8'($urandom), 32'($urandom)};
        endcase
        a = build_access(OP_PIXEL, 16'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom_range(0, 191)), keys, 1'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 57)
        begin
            a.op = (pick < 32) ? OP_MEM_WR : OP_MEM_RD;
            region = $urandom_range(0, 9);
            case (region)
                0: a.address = 16'($urandom_range(0, 16'h1FFF));
                1, 2: a.address = 16'h2000 + 16'($urandom_range(0, 16'h7FF));
                3, 4: a.address = 16'h2800 + 16'($urandom_range(0, 16'h7FF));
                5, 6:
                begin
                    a.address = 16'h3000 + 16'($urandom_range(0, 16'hFFF));
                    if (a.op == OP_MEM_RD)
                    begin
                        if (work_slots.size() == 0)
                            a.op = OP_MEM_WR;
                        else
                        begin
                            slot = work_slots[$urandom_range(0, work_slots.size() - 1)];
                            a.address = 16'h3000 + 16'($urandom_range(0, 3) << 10)
                                        + 16'(slot);
                        end
                    end
                end
                7, 8:
                begin
                    a.address = 16'($urandom_range(16'h4000, 16'hFFFF));
                    if (a.op == OP_MEM_RD)
                    begin
                        if (exp_slots.size() == 0)
                            a.op = OP_MEM_WR;
                        else
                        begin
                            slot = exp_slots[$urandom_range(0, exp_slots.size() - 1)];
                            if (slot < 16'h4000 && $urandom_range(0, 1) == 1)
                                a.address = 16'(slot + 16'hC000);
                            else
                                a.address = 16'(slot + 16'h4000);
                        end
                    end
                end
                default:
                begin
                    if (a.op == OP_MEM_WR)
                        a.address = 16'($urandom);
                    else
                        a.address = 16'($urandom_range(0, 16'h2FFF));
                end
            endcase
        end
        else if (pick < 78)
        begin
            a.op = (pick < 70) ? OP_IO_RD : OP_IO_WR;
            if ($urandom_range(0, 1) == 1)
                a.address[15:8] = ~(8'd1 << $urandom_range(0, 7));
            a.address[0] = ($urandom_range(0, 3) == 0);
        end
        else if ($urandom_range(0, 19) == 0)
            a.pixel_y = 8'($urandom_range(192, 255));
        return a;
    endfunction

    task automatic send_item(input access_t a);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = gaps_on ? $urandom_range(1, 8) : 0;
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid      <= 1'b1;
        req.op         <= a.op;
        req.address    <= a.address;
        req.write_data <= a.write_data;
        req.pixel_x    <= a.pixel_x;
        req.pixel_y    <= a.pixel_y;
        req.key_matrix <= a.key_matrix;
        req.tape_ear   <= a.tape_ear;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        pending_responses.push_back(access_result(a));
        op_items[int'(a.op)]++;
    endtask

    task automatic wait_drain();
        req.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // response side: stall pattern in segments, plus long holds on request
    initial
    begin
        int seg_left;
        int stall_pct;
        int hold_left;
        int holds_served;
        seg_left     = 0;
        stall_pct    = 0;
        hold_left    = 0;
        holds_served = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 20;
                        3: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                seg_left--;
                rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (pending_responses.size() == 0)
                report_mismatch("response with nothing expected", rsp.read_data, 8'h00);
            else
            begin
                want_rsp = pending_responses.pop_front();
                if (rsp.read_data !== want_rsp.read_data)
                    report_mismatch("read_data", rsp.read_data, want_rsp.read_data);
                if (rsp.rom_hit !== want_rsp.rom_hit)
                    report_mismatch("rom_hit", 8'(rsp.rom_hit), 8'(want_rsp.rom_hit));
                if (rsp.pixel_on !== want_rsp.pixel_on)
                    report_mismatch("pixel_on", 8'(rsp.pixel_on), 8'(want_rsp.pixel_on));
                if (rsp.beeper_level !== want_rsp.beeper_level)
                    report_mismatch("beeper_level", 8'(rsp.beeper_level),
                                    8'(want_rsp.beeper_level));
                responses_checked++;
            end
        end
    end

    task automatic test_cleared_stores();
        send_item(build_access(OP_MEM_RD, 16'h2000, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_PIXEL, 16'h0000, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_RD, 16'h2FFF, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        wait_drain();
    endtask

    task automatic test_memory_map();
        send_item(build_access(OP_MEM_WR, 16'h1FFF, 8'hFF, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_RD, 16'h0000, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_RD, 16'h1FFF, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_WR, 16'h2000, 8'h81, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_WR, 16'h27FF, 8'h55, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_RD, 16'h2400, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_RD, 16'h23FF, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_WR, 16'h2808, 8'hA5, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_WR, 16'h2FFF, 8'h3C, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_RD, 16'h2BFF, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_WR, 16'h3000, 8'h12, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_WR, 16'h3FFF, 8'hEE, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_RD, 16'h3C00, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_RD, 16'h33FF, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_WR, 16'h4000, 8'h77, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_WR, 16'hFFFF, 8'h99, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_RD, 16'hC000, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_MEM_RD, 16'h7FFF, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        wait_drain();
    endtask

    task automatic test_keyboard_port();
        send_item(build_access(OP_IO_RD, 16'h00FE, 8'h00, 8'h00, 8'h00,
                               40'hFF_FFFF_FFFF, 1'b1));
        send_item(build_access(OP_IO_WR, 16'h00FE, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_IO_WR, 16'h0001, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_IO_RD, 16'hFFFF, 8'h00, 8'h00, 8'h00,
                               40'hFF_FFFF_FFFF, 1'b0));
        send_item(build_access(OP_IO_RD, 16'hFF00, 8'h00, 8'h00, 8'h00, '0, 1'b0));
        send_item(build_access(OP_IO_RD, 16'h7FFE, 8'h00, 8'h00, 8'h00,
                               40'hF8_0000_0000, 1'b1));
        wait_drain();
    endtask

    task automatic test_pixel_lookup();
        send_item(build_access(OP_PIXEL, 16'h0000, 8'h00, 8'd0, 8'd0, '0, 1'b0));
        send_item(build_access(OP_PIXEL, 16'h0000, 8'h00, 8'd1, 8'd0, '0, 1'b0));
        send_item(build_access(OP_PIXEL, 16'h0000, 8'h00, 8'd255, 8'd191, '0, 1'b0));
        send_item(build_access(OP_PIXEL, 16'h0000, 8'h00, 8'd255, 8'd255, '0, 1'b0));
        wait_drain();
    endtask

    // long response hold while items keep coming, so the input stalls
    task automatic test_output_hold();
        hold_requests++;
        gaps_on = 1'b0;
        repeat (16) send_item(random_access());
        gaps_on = 1'b1;
        wait_drain();
    endtask

    // fill four cells and their glyph rows, then scan pixels over them
    task automatic test_pixel_scenes(input int scenes);
        int         r0;
        int         c0;
        logic [7:0] code;
        for (int s = 0; s < scenes; s++)
        begin
            r0 = $urandom_range(0, 23);
            c0 = $urandom_range(0, 28);
            for (int c = 0; c < 4; c++)
            begin
                code = 8'($urandom);
                send_item(build_access(OP_MEM_WR,
                                       16'h2000 + 16'($urandom_range(0, 1) << 10)
                                       + 16'(r0*32 + c0 + c),
                                       code, 8'($urandom), 8'($urandom), '0, 1'b0));
                for (int row = 0; row < 8; row++)
                    send_item(build_access(OP_MEM_WR,
                                           16'h2800 + 16'($urandom_range(0, 1) << 10)
                                           + 16'({code[6:0], 3'(row)}),
                                           8'($urandom), 8'($urandom), 8'($urandom),
                                           '0, 1'b0));
            end
            repeat (32)
                send_item(build_access(OP_PIXEL, 16'($urandom), 8'($urandom),
                                       8'(c0*8 + $urandom_range(0, 31)),
                                       8'(r0*8 + $urandom_range(0, 7)),
                                       {8'($urandom), 32'($urandom)}, 1'($urandom)));
        end
        wait_drain();
    endtask

    task automatic test_random_mix(input int count, input bit with_gaps);
        gaps_on = with_gaps;
        repeat (count) send_item(random_access());
        gaps_on = 1'b1;
        wait_drain();
    endtask

    initial
    begin
        error_count       = 0;
        responses_checked = 0;
        cycle_count       = 0;
        burst_left        = 0;
        gaps_on           = 1'b1;
        hold_requests     = 0;
        beeper_copy       = 1'b0;
        for (int i = 0; i < 5; i++)
            op_items[i] = 0;
        for (int i = 0; i < 1024; i++)
        begin
            video_copy[i] = 8'h00;
            glyph_copy[i] = 8'h00;
        end
        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.op         <= OP_MEM_RD;
        req.address    <= '0;
        req.write_data <= '0;
        req.pixel_x    <= '0;
        req.pixel_y    <= '0;
        req.key_matrix <= '0;
        req.tape_ear   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cleared_stores();
        test_memory_map();
        test_keyboard_port();
        test_pixel_lookup();
        test_output_hold();
        test_random_mix(450, 1'b1);
        test_random_mix(350, 1'b0);
        test_pixel_scenes(5);
        test_random_mix(400, 1'b1);

        if (pending_responses.size() != 0)
            report_mismatch("responses never delivered", 8'(pending_responses.size()), 8'h00);
        $display("sent %0d mem reads, %0d mem writes, %0d io reads, %0d io writes, %0d pixels",
                 op_items[int'(OP_MEM_RD)], op_items[int'(OP_MEM_WR)],
                 op_items[int'(OP_IO_RD)], op_items[int'(OP_IO_WR)],
                 op_items[int'(OP_PIXEL)]);
        $display("%0d responses compared under bursts, stalls and a %0d-cycle hold, %0d errors",
                 responses_checked, HOLD_CYCLES, error_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
